### src/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// shared types, codes and the size-class function of the free-list allocator
// ----------------------------------------------------------------------------
package sfa_pkg;

	localparam int ADDR_W       = 21;
	localparam int BYTES_W      = 32;
	localparam int COPY_W       = 13;
	localparam int UNITS_W      = 31;
	localparam int CLS_FN_W     = 14;

	localparam int CLASS_LIMIT_DEF  = 4097;
	localparam int REGION_UNITS_DEF = 262144;
	localparam int REGION_COUNT_DEF = 8;
	localparam int HEADER_UNITS_DEF = 5;

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_RESIZE = 2'd2;
	localparam logic [1:0] CMD_NOP    = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OOM       = 2'd1;
	localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [BYTES_W-1:0] byte_count;
		logic [ADDR_W-1:0]  block_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] result_address;
		logic [COPY_W-1:0] copy_units;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_ALLOC,
		S_HEAD,
		S_POP,
		S_SEARCH,
		S_PICK,
		S_BASE,
		S_CARVE,
		S_ALLOC_END,
		S_OLD_CLS,
		S_FREE_LINK,
		S_DONE
	} fsm_state_t;

	// round a unit count up to its size class; step doubles with each limit
	function automatic logic [CLS_FN_W-1:0] size_class(input logic [CLS_FN_W-1:0] u);
		logic [CLS_FN_W:0]   limit;
		logic [CLS_FN_W-1:0] step;
		logic [CLS_FN_W-1:0] sum;
		limit = (CLS_FN_W+1)'(64);
		step  = CLS_FN_W'(4);
		for (int i = 0; i < 8; i++) begin
			if ({1'b0, u} > limit) begin
				limit = limit << 1;
				step  = step << 1;
			end
		end
		sum = u + step - CLS_FN_W'(1);
		if (u == '0)
			return CLS_FN_W'(1);
		else if (u <= CLS_FN_W'(4))
			return u;
		else
			return sum & ~(step - CLS_FN_W'(1));
	endfunction

endpackage

### src/sfa_ram.sv
// ----------------------------------------------------------------------------
// sfa_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sfa_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### src/segregated_free_list_allocator.sv
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// size-class heap allocator over 4-byte units with per-class lifo free lists
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken when busy is low, and done pulses
// for exactly one cycle with the response; the receiver cannot stall it.
// How soon done comes depends on the path: a pop from a free list, a carve
// from a region, a free or a moving resize; busy drops in the cycle after
// done. The paths differ as the sequencer walks the dependent reads of the
// registered-read head table and block metadata rams, plus a registered
// region search on a carve. After reset all 2*CLASS_LIMIT head table entries
// are swept to empty, one entry per cycle, while busy stays high.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator #(
	parameter int CLASS_LIMIT  = sfa_pkg::CLASS_LIMIT_DEF,
	parameter int REGION_UNITS = sfa_pkg::REGION_UNITS_DEF,
	parameter int REGION_COUNT = sfa_pkg::REGION_COUNT_DEF,
	parameter int HEADER_UNITS = sfa_pkg::HEADER_UNITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sfa_pkg::req_t req,
	output logic          done,
	output sfa_pkg::rsp_t rsp
);

	import sfa_pkg::*;

	localparam int HEAD_SLOTS = 2 * CLASS_LIMIT;
	localparam int HA_W       = $clog2(HEAD_SLOTS);
	localparam int META_DEPTH = 2 ** ADDR_W;
	localparam int RL_W       = $clog2(REGION_UNITS + 1);
	localparam int RI_W       = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
	localparam int OC_W       = $clog2(REGION_COUNT + 1);
	localparam int CLS_W      = $clog2(CLASS_LIMIT - 1) + 1;
	localparam int FRESH      = REGION_UNITS - HEADER_UNITS;

	fsm_state_t state_q, state_d;

	// transaction registers
	logic [1:0]         cmd_q;
	logic [UNITS_W-1:0] units_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  old_q;
	logic [CLS_W-1:0]   cls_q;
	logic               move_q;
	logic [1:0]         status_q;
	logic [ADDR_W-1:0]  res_q;
	logic [COPY_W-1:0]  copy_q;
	logic [ADDR_W-1:0]  base_q;
	logic [HA_W-1:0]    clr_q;

	// region bookkeeping, small enough for flops
	logic [RL_W-1:0]         left_q  [REGION_COUNT];
	logic [RI_W-1:0]         order_q [REGION_COUNT];
	logic [OC_W-1:0]         opened_q;
	logic [REGION_COUNT-1:0] hit_q;

	// ram ports
	logic              head_we;
	logic [HA_W-1:0]   head_waddr, head_raddr;
	logic [ADDR_W-1:0] head_wdata, head_rdata;
	logic              meta_we;
	logic [ADDR_W-1:0] meta_waddr, meta_raddr, meta_wdata, meta_rdata;

	sfa_ram #(.WIDTH(ADDR_W), .DEPTH(HEAD_SLOTS)) u_heads (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	sfa_ram #(.WIDTH(ADDR_W), .DEPTH(META_DEPTH)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	// combinational helpers
	logic [CLS_FN_W-1:0] cls_full;
	logic [CLS_W-1:0]    cls_new;
	logic [CLS_W:0]      need;
	logic                too_large;
	logic                old_in_table;
	logic [UNITS_W-1:0]  units_min1;
	logic [ADDR_W-1:0]   addr_m1;
	logic [RI_W-1:0]     cur_r;
	logic [ADDR_W-1:0]   carve_h;
	logic                any_hit;
	logic [OC_W-1:0]     hit_pos;
	logic                can_open;

	assign too_large    = units_q >= UNITS_W'(CLASS_LIMIT);
	assign cls_full     = size_class(units_q[CLS_FN_W-1:0]);
	assign cls_new      = cls_full[CLS_W-1:0];
	assign need         = {1'b0, cls_q} + (CLS_W+1)'(1);
	assign old_in_table = old_q < ADDR_W'(HEAD_SLOTS);
	assign units_min1   = (units_q == '0) ? UNITS_W'(1) : units_q;
	assign addr_m1      = addr_q - ADDR_W'(1);
	assign cur_r        = order_q[0];
	assign carve_h      = ADDR_W'(32'(base_q) + 32'(REGION_UNITS) - 32'(left_q[cur_r]));
	assign can_open     = (opened_q < OC_W'(REGION_COUNT)) && (32'(need) <= 32'(FRESH));

	// first region in recency order with room
	always_comb begin
		any_hit = 1'b0;
		hit_pos = '0;
		for (int k = REGION_COUNT - 1; k >= 0; k--) begin
			if (hit_q[k]) begin
				any_hit = 1'b1;
				hit_pos = OC_W'(k);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == HA_W'(HEAD_SLOTS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start)
					state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (cmd_q)
					CMD_ALLOC:  state_d = S_ALLOC;
					CMD_FREE:   state_d = (addr_q == '0) ? S_DONE : S_OLD_CLS;
					CMD_RESIZE: state_d = (addr_q == '0) ? S_ALLOC : S_OLD_CLS;
					CMD_NOP:    state_d = S_DONE;
				endcase
			end
			S_ALLOC:     state_d = too_large ? S_DONE : S_HEAD;
			S_HEAD:      state_d = (head_rdata != '0) ? S_POP : S_SEARCH;
			S_POP:       state_d = S_ALLOC_END;
			S_SEARCH:    state_d = S_PICK;
			S_PICK:      state_d = (any_hit || can_open) ? S_BASE : S_DONE;
			S_BASE:      state_d = S_CARVE;
			S_CARVE:     state_d = S_ALLOC_END;
			S_ALLOC_END: state_d = (move_q && old_in_table) ? S_FREE_LINK : S_DONE;
			S_OLD_CLS: begin
				if (cmd_q == CMD_FREE)
					state_d = (meta_rdata < ADDR_W'(HEAD_SLOTS)) ? S_FREE_LINK : S_DONE;
				else if (UNITS_W'(meta_rdata) >= units_min1)
					state_d = S_DONE;
				else
					state_d = S_ALLOC;
			end
			S_FREE_LINK: state_d = S_DONE;
			S_DONE:      state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// ram controls; reads are issued in the state before their use
	always_comb begin
		head_we    = 1'b0;
		head_waddr = HA_W'(cls_q);
		head_wdata = meta_rdata;
		head_raddr = HA_W'(cls_new);
		meta_we    = 1'b0;
		meta_waddr = carve_h;
		meta_wdata = ADDR_W'(cls_q);
		meta_raddr = addr_m1;
		unique case (state_q)
			S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = '0;
			end
			S_HEAD: begin
				meta_raddr = head_rdata;
			end
			S_POP: begin
				// list head moves to the link stored in the popped block
				head_we = 1'b1;
			end
			S_CARVE: begin
				meta_we = 1'b1;
			end
			S_ALLOC_END: begin
				head_raddr = old_q[HA_W-1:0];
			end
			S_OLD_CLS: begin
				head_raddr = meta_rdata[HA_W-1:0];
			end
			S_FREE_LINK: begin
				// push: block links to old head, head points at block
				head_we    = 1'b1;
				head_waddr = old_q[HA_W-1:0];
				head_wdata = addr_q;
				meta_we    = 1'b1;
				meta_waddr = addr_q;
				meta_wdata = head_rdata;
			end
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		busy = state_q != S_IDLE;
		done = state_q == S_DONE;
		rsp.status         = status_q;
		rsp.result_address = res_q;
		rsp.copy_units     = copy_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			opened_q <= '0;
			for (int i = 0; i < REGION_COUNT; i++) begin
				left_q[i]  <= '0;
				order_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + HA_W'(1);
			if (state_q == S_PICK) begin
				if (hit_q[0]) begin
					// most recent region already has room
				end else if (any_hit) begin
					for (int j = REGION_COUNT - 1; j > 0; j--) begin
						if (OC_W'(j) <= hit_pos)
							order_q[j] <= order_q[j-1];
					end
					order_q[0] <= order_q[hit_pos[RI_W-1:0]];
				end else if (can_open) begin
					for (int j = REGION_COUNT - 1; j > 0; j--) begin
						if (OC_W'(j) <= opened_q)
							order_q[j] <= order_q[j-1];
					end
					order_q[0]                <= opened_q[RI_W-1:0];
					left_q[opened_q[RI_W-1:0]] <= RL_W'(FRESH);
					opened_q                  <= opened_q + OC_W'(1);
				end
			end
			if (state_q == S_CARVE)
				left_q[cur_r] <= left_q[cur_r] - RL_W'(need);
		end
	end

	// transaction datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q    <= req.cmd;
					units_q  <= UNITS_W'(((BYTES_W+1)'(req.byte_count) + (BYTES_W+1)'(3)) >> 2);
					addr_q   <= req.block_address;
					move_q   <= 1'b0;
					status_q <= STATUS_OK;
					res_q    <= '0;
					copy_q   <= '0;
				end
			end
			S_ALLOC: begin
				cls_q <= cls_new;
				if (too_large)
					status_q <= STATUS_TOO_LARGE;
			end
			S_HEAD: begin
				res_q <= head_rdata;
			end
			S_SEARCH: begin
				for (int k = 0; k < REGION_COUNT; k++)
					hit_q[k] <= (OC_W'(k) < opened_q) &&
						(32'(left_q[order_q[k]]) >= 32'(need));
			end
			S_PICK: begin
				if (!any_hit && !can_open)
					status_q <= STATUS_OOM;
			end
			S_BASE: begin
				base_q <= ADDR_W'(32'(cur_r) * 32'(REGION_UNITS));
			end
			S_CARVE: begin
				res_q <= carve_h + ADDR_W'(1);
			end
			S_ALLOC_END: begin
				if (move_q)
					copy_q <= old_q[COPY_W-1:0];
			end
			S_OLD_CLS: begin
				old_q <= meta_rdata;
				if (cmd_q == CMD_RESIZE) begin
					if (UNITS_W'(meta_rdata) >= units_min1)
						res_q <= addr_q;
					else
						move_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### verif/segregated_free_list_allocator_tb.sv
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_tb
// self-checking bench for the size-class allocator: a predictor of the class
// lists, block headers and regions forecasts every response, and a monitor
// compares each done pulse with the oldest forecast
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_tb;
	import sfa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLS_LIM   = CLASS_LIMIT_DEF;
	localparam int REG_UNITS = REGION_UNITS_DEF;
	localparam int REG_CNT   = REGION_COUNT_DEF;
	localparam int HDR_UNITS = HEADER_UNITS_DEF;
	localparam int HEAD_SLOTS = 2 * CLS_LIM;
	localparam int QUIET_LIMIT = 2 * HEAD_SLOTS + 2000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	req_t  req = '0;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	segregated_free_list_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #4 clk = ~clk;

	// predictor state: class list heads, per-unit metadata, region bookkeeping
	logic [ADDR_W-1:0] free_head [HEAD_SLOTS];
	logic [31:0]       unit_meta [logic [ADDR_W-1:0]];
	int unsigned       room_left [REG_CNT];
	int unsigned       mru_order [REG_CNT];
	int unsigned       opened_cnt;

	rsp_t              pending_rsp [$];
	logic [ADDR_W-1:0] live_blocks [$];  // addresses handed out and not freed
	int                fail_cnt = 0;
	int                idle_pct = 0;
	int                quiet_cnt = 0;

	function automatic logic [31:0] meta_rd(logic [ADDR_W-1:0] a);
		return unit_meta.exists(a) ? unit_meta[a] : 32'd0;
	endfunction

	function automatic int unsigned class_of(longint unsigned u);
		longint unsigned lim, stp;
		lim = 64;
		stp = 4;
		if (u == 0) return 1;
		if (u <= 4) return u;
		while (u > lim) begin
			lim *= 2;
			stp *= 2;
		end
		return ((u + stp - 1) / stp) * stp;
	endfunction

	function automatic void promote(int unsigned pos, int unsigned r);
		for (int unsigned j = pos; j > 0; j--)
			mru_order[j] = mru_order[j-1];
		mru_order[0] = r;
	endfunction

	function automatic logic [1:0] model_alloc(logic [31:0] nbytes,
		output logic [ADDR_W-1:0] addr);
		longint unsigned units;
		int unsigned cls, need, r, hdr;
		bit found;
		units = (longint'(nbytes) + 3) >> 2;
		addr = '0;
		if (units >= CLS_LIM) return STATUS_TOO_LARGE;
		cls = class_of(units);
		if (free_head[cls] != 0) begin
			addr = free_head[cls];
			free_head[cls] = ADDR_W'(meta_rd(addr));
			return STATUS_OK;
		end
		need = cls + 1;
		if (opened_cnt == 0 || room_left[mru_order[0]] < need) begin
			found = 0;
			for (int unsigned k = 0; k < opened_cnt && k < REG_CNT; k++) begin
				if (!found && room_left[mru_order[k]] >= need) begin
					promote(k, mru_order[k]);
					found = 1;
				end
			end
			if (!found) begin
				if (opened_cnt >= REG_CNT || (REG_UNITS - HDR_UNITS) < need)
					return STATUS_OOM;
				promote(opened_cnt, opened_cnt);
				room_left[opened_cnt] = REG_UNITS - HDR_UNITS;
				opened_cnt++;
			end
		end
		r = mru_order[0];
		hdr = (r * REG_UNITS + REG_UNITS - room_left[r]) & 32'h1FFFFF;
		room_left[r] -= need;
		unit_meta[hdr] = cls;
		addr = ADDR_W'(hdr + 1);
		return STATUS_OK;
	endfunction

	function automatic void model_free(logic [ADDR_W-1:0] a);
		logic [31:0] cls;
		if (a == 0) return;
		cls = meta_rd(a - 1'b1);
		if (cls >= HEAD_SLOTS) return;
		unit_meta[a] = free_head[cls];
		free_head[cls] = a;
	endfunction

	// forecast one response and keep the live-block list in step
	function automatic void predict_response(req_t r);
		rsp_t e;
		longint unsigned units;
		logic [31:0] old;
		e = '0;
		case (r.cmd)
			CMD_ALLOC: begin
				e.status = model_alloc(r.byte_count, e.result_address);
				if (e.status == STATUS_OK) live_blocks.push_back(e.result_address);
			end
			CMD_FREE: model_free(r.block_address);
			CMD_RESIZE: begin
				if (r.block_address == 0) begin
					e.status = model_alloc(r.byte_count, e.result_address);
					if (e.status == STATUS_OK) live_blocks.push_back(e.result_address);
				end else begin
					units = (longint'(r.byte_count) + 3) >> 2;
					old = meta_rd(r.block_address - 1'b1);
					if (units == 0) units = 1;
					if (old >= units) begin
						e.result_address = r.block_address;
					end else begin
						e.status = model_alloc(r.byte_count, e.result_address);
						if (e.status == STATUS_OK) begin
							e.copy_units = old[COPY_W-1:0];
							model_free(r.block_address);
							live_blocks.push_back(e.result_address);
						end
					end
				end
			end
			default: ;
		endcase
		pending_rsp.push_back(e);
	endfunction

	// issue one transaction, honoring the current idle percentage
	task automatic send_request(logic [1:0] cmd, logic [31:0] nbytes,
		logic [ADDR_W-1:0] addr);
		req_t r;
		r.cmd = cmd;
		r.byte_count = nbytes;
		r.block_address = addr;
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		start <= 1'b1;
		req   <= r;
		// busy only moves at a rising edge, so its value mid-cycle holds at the next edge
		do
			@(negedge clk);
		while (busy);
		@(posedge clk);
		predict_response(r);
		start <= 1'b0;
		@(posedge clk);
	endtask

	// picks a live block and removes it from the list (it is about to be freed or resized)
	function automatic logic [ADDR_W-1:0] take_live();
		int i;
		logic [ADDR_W-1:0] a;
		if (live_blocks.size() == 0) return '0;
		i = $urandom_range(live_blocks.size() - 1);
		a = live_blocks[i];
		live_blocks.delete(i);
		return a;
	endfunction

	function automatic logic [31:0] rand_bytes();
		case ($urandom_range(9))
			0: return $urandom;                      // mostly too large
			1: return $urandom_range(16388, 16000);  // around the limit
			2, 3: return $urandom_range(16384);
			default: return $urandom_range(260);
		endcase
	endfunction

	// response monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response status=%0d addr=%0d", rsp.status,
					rsp.result_address);
				fail_cnt++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					fail_cnt++;
				end
				if (rsp.result_address !== e.result_address) begin
					$error("result_address expected %0d actual %0d",
						e.result_address, rsp.result_address);
					fail_cnt++;
				end
				if (rsp.copy_units !== e.copy_units) begin
					$error("copy_units expected %0d actual %0d", e.copy_units,
						rsp.copy_units);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog: cycles with no transaction accepted either way
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cnt <= 0;
		else quiet_cnt <= quiet_cnt + 1;
		if (quiet_cnt >= QUIET_LIMIT) begin
			$display("segregated_free_list_allocator: mismatch");
			$finish;
		end
	end

	// extremes of size, every command and each corner case
	task automatic test_directed();
		logic [ADDR_W-1:0] a;
		send_request(CMD_ALLOC, 32'd0, '0);
		send_request(CMD_ALLOC, 32'd1, '0);
		send_request(CMD_ALLOC, 32'd16384, '0);            // 4096 units, biggest class
		send_request(CMD_ALLOC, 32'd16385, '0);            // too large
		send_request(CMD_ALLOC, 32'hFFFF_FFFF, '0);        // too large, all ones
		send_request(CMD_RESIZE, 32'hFFFF_FFFF, '0);
		send_request(CMD_ALLOC, 32'd257, '0);              // rounded class
		send_request(CMD_FREE, 32'd0, '0);                 // free of address zero
		send_request(CMD_NOP, 32'hFFFF_FFFF, 21'h1FFFFF);  // unused command
		send_request(CMD_RESIZE, 32'd20, '0);              // resize of none allocates
		a = take_live();
		send_request(CMD_RESIZE, 32'd0, a);                // size zero keeps the block
		send_request(CMD_RESIZE, 32'd4000, a);             // resize to 1000 units; moves if the block is smaller
		a = take_live();
		send_request(CMD_FREE, 32'd0, a);
		send_request(CMD_ALLOC, 32'd4000, '0);             // pops from the free list if the freed block is of its class
		a = take_live();
		send_request(CMD_FREE, 32'd0, a);
		send_request(CMD_FREE, 32'd0, a);                  // double free
		send_request(CMD_ALLOC, 32'd4000, '0);
		send_request(CMD_ALLOC, 32'd4000, '0);
	endtask

	// fill regions with big blocks until memory runs out, then free some
	task automatic test_exhaustion();
		int n;
		n = 0;
		while (n < 560 && !(pending_rsp.size() == 0 && 0)) begin
			send_request(CMD_ALLOC, 32'd16384, '0);
			n++;
		end
		send_request(CMD_RESIZE, 32'd16384, live_blocks.size() ? live_blocks[0] : '0);
		repeat (40) send_request(CMD_FREE, 32'd0, take_live());
		repeat (20) send_request(CMD_ALLOC, $urandom_range(16384, 8000), '0);
	endtask

	task automatic test_random(int count);
		int sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 45 || live_blocks.size() == 0)
				send_request($urandom_range(1) ? CMD_ALLOC : CMD_RESIZE, rand_bytes(), '0);
			else if (sel < 75)
				send_request(CMD_FREE, $urandom, take_live());
			else if (sel < 95) begin
				// resize of a live block; it stays live unless it moves
				int k;
				k = $urandom_range(live_blocks.size() - 1);
				send_request(CMD_RESIZE, rand_bytes(), live_blocks[k]);
				if (pending_rsp.size() && pending_rsp[$].copy_units != 0)
					live_blocks.delete(k);
			end else
				send_request($urandom_range(1) ? CMD_NOP : CMD_FREE, $urandom, '0);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 0;
		test_directed();
		test_random(200);
		idle_pct = 81;
		test_random(200);
		idle_pct = 38;
		test_random(200);
		idle_pct = 0;
		test_exhaustion();
		test_random(200);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_cnt == 0)
			$display("segregated_free_list_allocator: match");
		else
			$display("segregated_free_list_allocator: mismatch");
		$finish;
	end

endmodule

### filelist.f
src/sfa_pkg.sv
src/sfa_ram.sv
src/segregated_free_list_allocator.sv
verif/segregated_free_list_allocator_tb.sv
